// File: hw/rtl/ics_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ics_pkg - shared types and helpers for the word-stream Internet checksum
// Holds the word and sum payload types, the byte order codes and the byte
// mask helper used by the accumulator.
// ---------------------------------------------------------------------------
package ics_pkg;

    localparam int ICS_WORD_BYTES = 8;
    localparam int ICS_DATA_W     = 64;
    localparam int ICS_SUM_W      = 16;
    localparam int ICS_SKIP_W     = 3;
    localparam int ICS_KEEP_W     = 4;

    localparam logic ICS_ORDER_LE = 1'b0;
    localparam logic ICS_ORDER_BE = 1'b1;

    typedef struct packed {
        logic [ICS_DATA_W-1:0] data_word;
        logic                  first_word;
        logic                  last_word;
        logic [ICS_SKIP_W-1:0] head_skip;
        logic [ICS_KEEP_W-1:0] tail_keep;
    } ics_word_t;

    typedef struct packed {
        logic [ICS_DATA_W-1:0] sum;
        logic                  odd;
    } ics_sum_t;

    // Ones in the low nbytes bytes; eight or more gives all ones.
    function automatic logic [ICS_DATA_W-1:0] ics_byte_mask(input logic [ICS_KEEP_W-1:0] nbytes);
        logic [ICS_DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < ICS_DATA_W / 8; i++)
        begin
            if (ICS_KEEP_W'(i) < nbytes)
            begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ics_word_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ics_word_if - input word stream channel
// Carries valid, ready and one aligned buffer word with its framing fields.
// ---------------------------------------------------------------------------
interface ics_word_if
    import ics_pkg::*;
    ();

    logic                  valid;
    logic                  ready;
    logic [ICS_DATA_W-1:0] data_word;
    logic                  first_word;
    logic                  last_word;
    logic [ICS_SKIP_W-1:0] head_skip;
    logic [ICS_KEEP_W-1:0] tail_keep;

    modport source (
        output valid, data_word, first_word, last_word, head_skip, tail_keep,
        input  ready
    );

    modport sink (
        input  valid, data_word, first_word, last_word, head_skip, tail_keep,
        output ready
    );

endinterface
`default_nettype wire

// File: hw/rtl/ics_sum_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ics_sum_if - checksum result channel
// Carries valid, ready and the folded 16-bit checksum of one buffer.
// ---------------------------------------------------------------------------
interface ics_sum_if
    import ics_pkg::*;
    ();

    logic                 valid;
    logic                 ready;
    logic [ICS_SUM_W-1:0] checksum;

    modport source (
        output valid, checksum,
        input  ready
    );

    modport sink (
        input  valid, checksum,
        output ready
    );

endinterface
`default_nettype wire

// File: hw/rtl/internet_checksum_word_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// internet_checksum_word_stream_top - streaming Internet checksum over words
// Path: the checksum of a buffer is valid once its last word has passed the
//   input register loaded by the transfer, the accumulate register and the
//   fold/output register; the result transfers when result.ready is high.
// Throughput: one word per cycle, set by the end-around add into the running
//   sum, unless a last word waits on the result register; results leave at up to one per cycle.
// Reset: rst_n clears the running sum, odd-start flag, byte order (little
//   endian) and all valid flags; no clearing pass is needed.
// ---------------------------------------------------------------------------
module internet_checksum_word_stream_top
    import ics_pkg::*;
#(
    parameter int WORD_BYTES = ICS_WORD_BYTES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    ics_word_if.sink  words,
    ics_sum_if.source result
);

    // Byte order register; the user must write it only while the block is idle (not enforced here).
    logic      byte_order_reg, byte_order_next;

    // Input register: one word in flight ahead of the accumulator.
    logic      s1_valid_reg, s1_valid_next;
    ics_word_t s1_item_reg, s1_item_next;

    logic      item_take;
    logic      s1_free;
    logic      accept;
    logic      done_valid;
    ics_sum_t  done;
    logic      done_take;

    // Take a new word whenever the input register is empty or drains now.
    assign s1_free     = !s1_valid_reg || item_take;
    assign words.ready = s1_free;
    assign accept      = words.valid && s1_free;

    always_comb
    begin
        byte_order_next = cfg_we ? cfg_wdata : byte_order_reg;

        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        if (item_take)
            s1_valid_next = 1'b0;
        if (accept)
        begin
            // Capture the transfer; it overlaps with the word leaving.
            s1_valid_next           = 1'b1;
            s1_item_next.data_word  = words.data_word;
            s1_item_next.first_word = words.first_word;
            s1_item_next.last_word  = words.last_word;
            s1_item_next.head_skip  = words.head_skip;
            s1_item_next.tail_keep  = words.tail_keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_reg <= ICS_ORDER_LE;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_order_reg <= byte_order_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    // Mask partial words and advance the one's-complement sum.
    ics_accum #(
        .WORD_BYTES (WORD_BYTES)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_order (byte_order_reg),
        .item_valid (s1_valid_reg),
        .item       (s1_item_reg),
        .item_take  (item_take),
        .done_valid (done_valid),
        .done       (done),
        .done_take  (done_take)
    );

    // Fold the closed sum to 16 bits and hold it for the result transfer.
    ics_fold #(
        .WORD_BYTES (WORD_BYTES)
    ) u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .done_valid (done_valid),
        .done       (done),
        .done_take  (done_take),
        .result     (result)
    );

endmodule
`default_nettype wire

// File: hw/rtl/ics_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ics_accum - masking and one's-complement accumulation
// Clears head and tail bytes of partial words, adds each word with
// end-around carry, and registers the final sum of a buffer.
// ---------------------------------------------------------------------------
module ics_accum
    import ics_pkg::*;
#(
    parameter int WORD_BYTES = ICS_WORD_BYTES
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_order,
    input  wire logic      item_valid,
    input  wire ics_word_t item,
    output logic           item_take,
    output logic           done_valid,
    output ics_sum_t       done,
    input  wire logic      done_take
);

    localparam int WORD_W = WORD_BYTES * 8;
    localparam logic [ICS_KEEP_W-1:0] WB = ICS_KEEP_W'(WORD_BYTES);

    logic [ICS_DATA_W-1:0] sum_reg, sum_next;
    logic                  odd_reg, odd_next;
    logic                  done_valid_reg, done_valid_next;
    ics_sum_t              done_reg, done_next;

    logic [ICS_DATA_W-1:0] word_mask;
    logic [ICS_KEEP_W-1:0] skip_c;
    logic [ICS_KEEP_W-1:0] keep_c;
    logic [ICS_DATA_W-1:0] data;
    logic [ICS_DATA_W-1:0] base;
    logic [ICS_DATA_W:0]   sum_wide;
    logic                  carry;
    logic [ICS_DATA_W-1:0] new_sum;
    logic                  odd_now;
    logic                  done_free;

    assign word_mask = ics_byte_mask(WB);
    assign done_free = !done_valid_reg || done_take;
    // Hold a last word until the result register can take its sum.
    assign item_take = item_valid && (!item.last_word || done_free);

    always_comb
    begin
        skip_c = ({1'b0, item.head_skip} > WB) ? WB : {1'b0, item.head_skip};
        keep_c = (item.tail_keep > WB) ? WB : item.tail_keep;

        data = item.data_word & word_mask;
        if (item.first_word)
        begin
            if (byte_order == ICS_ORDER_LE)
                data = data & ~ics_byte_mask(skip_c);
            else
                data = data & ics_byte_mask(WB - skip_c);
        end
        if (item.last_word)
        begin
            if (byte_order == ICS_ORDER_LE)
                data = data & ics_byte_mask(keep_c);
            else
                data = data & ~ics_byte_mask(WB - keep_c);
        end
        data = data & word_mask;

        base     = item.first_word ? '0 : sum_reg;
        sum_wide = {1'b0, base} + {1'b0, data};
        carry    = sum_wide[WORD_W];
        new_sum  = (sum_wide[ICS_DATA_W-1:0] & word_mask) + {{(ICS_DATA_W-1){1'b0}}, carry};
        odd_now  = item.first_word ? skip_c[0] : odd_reg;
    end

    always_comb
    begin
        sum_next        = sum_reg;
        odd_next        = odd_reg;
        done_valid_next = done_valid_reg;
        done_next       = done_reg;
        if (done_take)
            done_valid_next = 1'b0;
        if (item_take)
        begin
            if (item.last_word)
            begin
                // Drop the running state once the buffer closes.
                sum_next        = '0;
                odd_next        = 1'b0;
                done_valid_next = 1'b1;
                done_next.sum   = new_sum;
                done_next.odd   = odd_now;
            end
            else
            begin
                sum_next = new_sum;
                odd_next = odd_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            odd_reg        <= 1'b0;
            done_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            odd_reg        <= odd_next;
            done_valid_reg <= done_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        done_reg <= done_next;
    end

    assign done_valid = done_valid_reg;
    assign done       = done_reg;

endmodule
`default_nettype wire

// File: hw/rtl/ics_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ics_fold - fold to 16 bits and output register
// Folds the word sum in 16-bit chunks with end-around carry, swaps bytes
// for an odd start, and holds the checksum for the result channel.
// ---------------------------------------------------------------------------
module ics_fold
    import ics_pkg::*;
#(
    parameter int WORD_BYTES = ICS_WORD_BYTES
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     done_valid,
    input  wire ics_sum_t done,
    output logic          done_take,
    ics_sum_if.source     result
);

    localparam int NCHUNK = ((WORD_BYTES * 8 + 15) / 16 < 4) ? (WORD_BYTES * 8 + 15) / 16 : 4;

    logic                 out_valid_reg, out_valid_next;
    logic [ICS_SUM_W-1:0] checksum_reg, checksum_next;
    logic [ICS_SUM_W:0]   r;
    logic [ICS_SUM_W-1:0] folded;
    logic                 out_free;

    assign out_free  = !out_valid_reg || result.ready;
    assign done_take = done_valid && out_free;

    always_comb
    begin
        r = '0;
        for (int i = 0; i < NCHUNK; i++)
        begin
            r = r + {1'b0, done.sum[16*i +: 16]};
            r = {1'b0, r[ICS_SUM_W-1:0]} + {{ICS_SUM_W{1'b0}}, r[ICS_SUM_W]};
        end
        folded = r[ICS_SUM_W-1:0];
        if (done.odd)
            folded = {folded[7:0], folded[15:8]};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        checksum_next  = checksum_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (done_take)
        begin
            out_valid_next = 1'b1;
            checksum_next  = folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        checksum_reg <= checksum_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.checksum = checksum_reg;

endmodule
`default_nettype wire
